[src/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg
// Shared constants, codes and structs of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int LIST_DEPTH  = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  // fixed stream field widths
  localparam int ITEM_W  = 32;
  localparam int POS_W   = 5;
  localparam int ECNT_W  = 5;
  localparam int TUSER_W = 2;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int TDATA_W = ((ITEM_W + POS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_MOVE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    req_e                   kind;
    logic [VALUE_WIDTH-1:0] value;
    logic [POS_W-1:0]       position;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [VALUE_WIDTH-1:0] removed;
    logic [CNT_W-1:0]       count;
  } res_t;

  typedef struct packed {
    logic                   we;
    logic [IDX_W-1:0]       waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic [IDX_W-1:0]       raddr;
  } mem_req_t;

endpackage

[src/ple_ram.sv]
// ----------------------------------------------------------------------------
// ple_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/ple_ctrl.sv]
// ----------------------------------------------------------------------------
// ple_ctrl
// Request sequencer: decides each request, searches the list memory and
// moves entries one at a time by read then write-back.
// ----------------------------------------------------------------------------
module ple_ctrl import ple_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  req_t                   req_i,
  output logic                   ready_o,
  output logic                   done_o,
  input  logic                   take_i,
  output res_t                   res_o,
  output mem_req_t               mem_o,
  input  logic [VALUE_WIDTH-1:0] rdata_i
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SEARCH  = 8'b0000_0010,
    S_REM_RD  = 8'b0000_0100,
    S_REM_CAP = 8'b0000_1000,
    S_SH_RD   = 8'b0001_0000,
    S_SH_WR   = 8'b0010_0000,
    S_FINAL   = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [CMP_W-1:0]       pos_q, pos_d;
  logic [CNT_W-1:0]       sidx_q, sidx_d;
  logic                   chk_q, chk_d;
  logic                   up_q, up_d;
  logic [IDX_W-1:0]       dst_q, dst_d;
  logic [IDX_W-1:0]       end_q, end_d;
  logic                   fin_q, fin_d;
  res_t                   res_q, res_d;

  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic             full;
  logic [IDX_W-1:0] src;
  logic [IDX_W-1:0] at;

  assign pos_c = CMP_W'(req_i.position);
  assign cnt_c = CMP_W'(cnt_q);
  assign full  = (cnt_q >= CNT_W'(LIST_DEPTH));
  assign src   = up_q ? (dst_q - IDX_W'(1)) : (dst_q + IDX_W'(1));
  assign at    = IDX_W'(sidx_q - CNT_W'(1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    val_d   = val_q;
    pos_d   = pos_q;
    sidx_d  = sidx_q;
    chk_d   = chk_q;
    up_d    = up_q;
    dst_d   = dst_q;
    end_d   = end_q;
    fin_d   = fin_q;
    res_d   = res_q;
    mem_o.we    = 1'b0;
    mem_o.waddr = dst_q;
    mem_o.wdata = rdata_i;
    mem_o.raddr = src;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          val_d         = req_i.value;
          pos_d         = pos_c;
          fin_d         = 1'b1;
          res_d.status  = ST_OK;
          res_d.removed = '0;
          res_d.count   = cnt_q;
          state_d       = S_DONE;
          unique case (req_i.kind)
            REQ_APPEND: begin
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                pos_d       = cnt_c;
                res_d.count = cnt_q + CNT_W'(1);
                state_d     = S_FINAL;
              end
            end
            REQ_INSERT: begin
              if (full) begin
                res_d.status = ST_FULL;
              end else if (pos_c > cnt_c) begin
                res_d.status = ST_BADPOS;
              end else begin
                res_d.count = cnt_q + CNT_W'(1);
                if (pos_c == cnt_c) begin
                  state_d = S_FINAL;
                end else begin
                  // open a gap: entries from the tail down to pos move up
                  up_d    = 1'b1;
                  dst_d   = IDX_W'(cnt_q);
                  end_d   = IDX_W'(pos_c) + IDX_W'(1);
                  state_d = S_SH_RD;
                end
              end
            end
            REQ_REMOVE: begin
              if (pos_c >= cnt_c) begin
                res_d.status = ST_BADPOS;
              end else begin
                res_d.count = cnt_q - CNT_W'(1);
                state_d     = S_REM_RD;
              end
            end
            REQ_MOVE: begin
              sidx_d  = '0;
              chk_d   = 1'b0;
              state_d = S_SEARCH;
            end
          endcase
        end
      end

      S_SEARCH: begin
        // read address sidx issued each cycle, data of sidx-1 compared
        if (chk_q && (rdata_i == val_q)) begin
          state_d = S_DONE;
          if (pos_q >= cnt_c) begin
            res_d.status = ST_BADPOS;
          end else if (CMP_W'(at) != pos_q) begin
            dst_d = at;
            if (CMP_W'(at) < pos_q) begin
              up_d  = 1'b0;
              end_d = IDX_W'(pos_q) - IDX_W'(1);
            end else begin
              up_d  = 1'b1;
              end_d = IDX_W'(pos_q) + IDX_W'(1);
            end
            state_d = S_SH_RD;
          end
        end else if (sidx_q == cnt_q) begin
          res_d.status = ST_NOTFOUND;
          state_d      = S_DONE;
        end else begin
          mem_o.raddr = IDX_W'(sidx_q);
          sidx_d      = sidx_q + CNT_W'(1);
          chk_d       = 1'b1;
        end
      end

      S_REM_RD: begin
        mem_o.raddr = IDX_W'(pos_q);
        state_d     = S_REM_CAP;
      end

      S_REM_CAP: begin
        res_d.removed = rdata_i;
        fin_d         = 1'b0;
        if (pos_q == cnt_c - CMP_W'(1)) begin
          state_d = S_DONE;
        end else begin
          // close the gap: entries after pos move down
          up_d    = 1'b0;
          dst_d   = IDX_W'(pos_q);
          end_d   = IDX_W'(cnt_q - CNT_W'(2));
          state_d = S_SH_RD;
        end
      end

      S_SH_RD: begin
        mem_o.raddr = src;
        state_d     = S_SH_WR;
      end

      S_SH_WR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = dst_q;
        mem_o.wdata = rdata_i;
        if (dst_q == end_q) begin
          state_d = fin_q ? S_FINAL : S_DONE;
        end else begin
          dst_d   = up_q ? (dst_q - IDX_W'(1)) : (dst_q + IDX_W'(1));
          state_d = S_SH_RD;
        end
      end

      S_FINAL: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = IDX_W'(pos_q);
        mem_o.wdata = val_q;
        state_d     = S_DONE;
      end

      S_DONE: begin
        if (take_i) begin
          cnt_d   = res_q.count;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    pos_q  <= pos_d;
    sidx_q <= sidx_d;
    chk_q  <= chk_d;
    up_q   <= up_d;
    dst_q  <= dst_d;
    end_q  <= end_d;
    fin_q  <= fin_d;
    res_q  <= res_d;
  end

  assign ready_o = (state_q == S_IDLE);
  assign done_o  = (state_q == S_DONE);
  assign res_o   = res_q;

`ifndef ASSERT_OFF
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.we |-> (state_q == S_SH_WR || state_q == S_FINAL))
    else $error("list memory written outside a write step");

  a_we_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.we |-> (CNT_W'(mem_o.waddr) < CNT_W'(LIST_DEPTH)))
    else $error("list memory write beyond depth");

  a_cnt_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> $past(state_q == S_DONE))
    else $error("count changed outside result hand-off");

  a_res_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (res_q.count <= CNT_W'(LIST_DEPTH)))
    else $error("result count exceeds depth");
`endif

endmodule

[src/positional_list_engine.sv]
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list with append, insert, remove and move-by-value requests.
// Sequence: append writes the value; insert shifts entries up, each by a read
//   and a write-back, then writes the value; remove reads the removed entry and
//   shifts down with no final write; move searches, then rotates and writes.
// Throughput: one request at a time, set by the single read and single write
//   port of the list memory that every shifted entry goes through.
// Reset: count and handshakes cleared at once; list memory is not cleared.
// ----------------------------------------------------------------------------
module positional_list_engine import ple_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // item_value, position, zero pad
  input  logic [TUSER_W-1:0] s_axis_tuser,   // req_type
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // removed_value, entry_count, zero pad
  output logic [TUSER_W-1:0] m_axis_tuser    // status
);

  req_t                   req;
  res_t                   res;
  mem_req_t               mem;
  logic [VALUE_WIDTH-1:0] rdata;
  logic                   ready;
  logic                   done;
  logic                   take;

  logic m_valid_q, m_valid_d;
  res_t out_q;

  assign req.kind     = req_e'(s_axis_tuser[1:0]);
  assign req.value    = VALUE_WIDTH'(s_axis_tdata[ITEM_W-1:0]);
  assign req.position = s_axis_tdata[ITEM_W +: POS_W];

  ple_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_axis_tvalid && ready),
    .req_i   (req),
    .ready_o (ready),
    .done_o  (done),
    .take_i  (take),
    .res_o   (res),
    .mem_o   (mem),
    .rdata_i (rdata)
  );

  ple_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem.we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.wdata),
    .raddr_i (mem.raddr),
    .rdata_o (rdata)
  );

  // output register: a finished result loads once the previous one is gone
  assign take      = done && (!m_valid_q || m_axis_tready);
  assign m_valid_d = take || (m_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign s_axis_tready = ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TDATA_W'({ECNT_W'(out_q.count), ITEM_W'(out_q.removed)});
  assign m_axis_tuser  = TUSER_W'(out_q.status);

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list engine. A queue of planned
// requests feeds a bursty stream driver. Each accepted request is run
// through a local copy of the list to give the expected status, removed
// value and count. A monitor with its own stall pattern checks every
// result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ple_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 200;

  typedef struct packed {
    status_e                status;
    logic [VALUE_WIDTH-1:0] removed;
    logic [ECNT_W-1:0]      count;
  } list_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata  = '0;
  logic [TUSER_W-1:0] s_axis_tuser  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [TUSER_W-1:0] m_axis_tuser;

  positional_list_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // expected list contents, updated per accepted request
  // ---------------------------------------------------------------------------
  logic [VALUE_WIDTH-1:0] list_vals [LIST_DEPTH];
  int unsigned            list_len = 0;
  list_result_t           expected_results [$];

  function automatic void shift_in(int unsigned idx, logic [VALUE_WIDTH-1:0] v);
    for (int unsigned i = list_len; i > idx; i--) list_vals[i] = list_vals[i-1];
    list_vals[idx] = v;
    list_len++;
  endfunction

  function automatic void shift_out(int unsigned idx);
    for (int unsigned i = idx; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
    list_len--;
  endfunction

  function automatic void predict_request(req_t r);
    list_result_t e;
    int           at;
    e.status  = ST_OK;
    e.removed = '0;
    at        = -1;
    case (r.kind)
      REQ_APPEND: begin
        if (list_len >= LIST_DEPTH) e.status = ST_FULL;
        else shift_in(list_len, r.value);
      end
      REQ_INSERT: begin
        // full is reported ahead of a bad position
        if (list_len >= LIST_DEPTH) e.status = ST_FULL;
        else if (r.position > list_len) e.status = ST_BADPOS;
        else shift_in(r.position, r.value);
      end
      REQ_REMOVE: begin
        if (r.position >= list_len) begin
          e.status = ST_BADPOS;
        end else begin
          e.removed = list_vals[r.position];
          shift_out(r.position);
        end
      end
      default: begin
        for (int i = 0; i < int'(list_len); i++) begin
          if (at < 0 && list_vals[i] == r.value) at = i;
        end
        // target index counts in the list with the entry taken out
        if (at < 0) e.status = ST_NOTFOUND;
        else if (r.position > list_len - 1) e.status = ST_BADPOS;
        else begin
          shift_out(at);
          shift_in(r.position, r.value);
        end
      end
    endcase
    e.count = ECNT_W'(list_len);
    expected_results.push_back(e);
  endfunction

  // ---------------------------------------------------------------------------
  // request planning, with a rough view of the list to aim positions and values
  // ---------------------------------------------------------------------------
  req_t                   pending_reqs [$];
  logic [VALUE_WIDTH-1:0] plan_vals [$];
  logic [VALUE_WIDTH-1:0] value_pool [6] = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
                                             32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

  task automatic plan_request(req_e kind, logic [VALUE_WIDTH-1:0] v, int pos);
    req_t r;
    int   at;
    r.kind     = kind;
    r.value    = v;
    r.position = POS_W'(pos);
    at         = -1;
    case (kind)
      REQ_APPEND: if (plan_vals.size() < LIST_DEPTH) plan_vals.push_back(v);
      REQ_INSERT: if (plan_vals.size() < LIST_DEPTH && pos <= plan_vals.size())
                    plan_vals.insert(pos, v);
      REQ_REMOVE: if (pos < plan_vals.size()) plan_vals.delete(pos);
      default: begin
        for (int i = 0; i < plan_vals.size(); i++)
          if (at < 0 && plan_vals[i] == v) at = i;
        if (at >= 0 && pos <= plan_vals.size() - 1) begin
          plan_vals.delete(at);
          plan_vals.insert(pos, v);
        end
      end
    endcase
    pending_reqs.push_back(r);
  endtask

  // trend 0 grows the list, 1 shrinks it, 2 keeps it balanced
  task automatic plan_random(int trend);
    int                     roll;
    int                     len;
    int                     pos;
    bit                     wild;
    req_e                   kind;
    logic [VALUE_WIDTH-1:0] v;
    len  = plan_vals.size();
    roll = $urandom_range(0, 99);
    wild = ($urandom_range(0, 9) == 0);
    case (trend)
      0:       kind = roll < 35 ? REQ_APPEND : roll < 70 ? REQ_INSERT :
                      roll < 85 ? REQ_REMOVE : REQ_MOVE;
      1:       kind = roll < 10 ? REQ_APPEND : roll < 20 ? REQ_INSERT :
                      roll < 80 ? REQ_REMOVE : REQ_MOVE;
      default: kind = roll < 25 ? REQ_APPEND : roll < 50 ? REQ_INSERT :
                      roll < 75 ? REQ_REMOVE : REQ_MOVE;
    endcase
    case (kind)
      REQ_APPEND: pos = $urandom_range(0, 31);
      REQ_INSERT: pos = wild ? $urandom_range(0, 31) : $urandom_range(0, len);
      default:    pos = (wild || len == 0) ? $urandom_range(0, 31) : $urandom_range(0, len - 1);
    endcase
    // small pool makes duplicates so moves must pick the first match
    if (kind == REQ_MOVE && len > 0 && $urandom_range(0, 3) != 0)
      v = plan_vals[$urandom_range(0, len - 1)];
    else if ($urandom_range(0, 1) == 0)
      v = value_pool[$urandom_range(0, 5)];
    else
      v = $urandom;
    plan_request(kind, v, pos);
  endtask

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  req_t offered_req;
  int   burst_left = 0;
  int   gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_request(offered_req);
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the request until taken
      end else if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        offered_req   <= pending_reqs[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'({pending_reqs[0].position, pending_reqs[0].value});
        s_axis_tuser  <= pending_reqs[0].kind;
        pending_reqs.delete(0);
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver stalls
  // ---------------------------------------------------------------------------
  list_result_t want;
  int           mismatches   = 0;
  int           results_seen = 0;
  int           rx_mode      = 0;
  int           rx_span      = 0;
  int           holdoff_left = 0;
  bit           holdoff_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_mode       <= 0;
      rx_span       <= 0;
      holdoff_left  <= 0;
      holdoff_done  <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("%0t: result with none pending: status %0d removed %h count %0d",
                     $realtime, m_axis_tuser, m_axis_tdata[ITEM_W-1:0],
                     m_axis_tdata[ITEM_W +: ECNT_W]);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser != want.status || m_axis_tdata[ITEM_W-1:0] != want.removed ||
              m_axis_tdata[ITEM_W +: ECNT_W] != want.count) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("%0t: mismatch exp status %0d removed %h count %0d, got %0d %h %0d",
                       $realtime, want.status, want.removed, want.count, m_axis_tuser,
                       m_axis_tdata[ITEM_W-1:0], m_axis_tdata[ITEM_W +: ECNT_W]);
          end
        end
      end
      if (holdoff_left > 0) begin
        m_axis_tready <= 1'b0;
        holdoff_left  <= holdoff_left - 1;
      end else if (!holdoff_done && results_seen >= 500) begin
        // long back-pressure so the engine fills and stalls its input
        holdoff_done  <= 1'b1;
        holdoff_left  <= 400;
        m_axis_tready <= 1'b0;
      end else begin
        if (rx_span == 0) begin
          rx_mode <= $urandom_range(0, 2);
          rx_span <= $urandom_range(20, 200);
        end else begin
          rx_span <= rx_span - 1;
        end
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog on cycles without any handshake
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list corner cases
    plan_request(REQ_REMOVE, 32'h0, 0);
    plan_request(REQ_MOVE,   32'h5, 0);
    plan_request(REQ_INSERT, 32'h9, 1);
    // extreme values, insert at front, at the end and past the end
    plan_request(REQ_APPEND, 32'h7FFF_FFFF, 31);
    plan_request(REQ_APPEND, 32'h8000_0000, 0);
    plan_request(REQ_INSERT, 32'h0000_0000, 0);
    plan_request(REQ_INSERT, 32'hFFFF_FFFF, 3);
    plan_request(REQ_INSERT, 32'h0000_0001, 31);
    // moves to front, to last slot, past last slot, and a missing value
    plan_request(REQ_MOVE,   32'h8000_0000, 0);
    plan_request(REQ_MOVE,   32'hFFFF_FFFF, 3);
    plan_request(REQ_MOVE,   32'h0000_0000, 4);
    plan_request(REQ_MOVE,   32'd12345, 0);
    // duplicate values, move takes the first one
    plan_request(REQ_APPEND, 32'h5, 0);
    plan_request(REQ_APPEND, 32'h5, 0);
    plan_request(REQ_MOVE,   32'h5, 0);
    // remove last, past the end, and front
    plan_request(REQ_REMOVE, 32'h0, 5);
    plan_request(REQ_REMOVE, 32'h0, 31);
    plan_request(REQ_REMOVE, 32'h0, 0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      for (int n = 0; n < PHASE_REQS; n++) plan_random(p % 3);
      // sender stays quiet until every result of the phase is back
      wait_drained();
    end

    repeat (100) @(negedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
